### sv/tmap_pkg.sv
// shared types and constants of the tempo map lookup
package tmap_pkg;

  localparam int POS_W    = 40;
  localparam int SPQ_W    = 20;
  localparam int QPB_W    = 26;
  localparam int SIG_W    = 8;
  localparam int SLOT_W   = 6;
  localparam int CFG_W    = 7;
  localparam int HALF_W   = 20;
  localparam int PROD_W   = HALF_W + QPB_W;
  localparam int ACC_W    = POS_W + QPB_W;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_SEC     = 2'd1;
  localparam logic [1:0] OP_QUARTER = 2'd2;
  localparam logic [1:0] OP_BAR     = 2'd3;

  typedef struct packed {
    logic [POS_W-1:0] start_sec;
    logic [POS_W-1:0] start_quarter;
    logic [POS_W-1:0] start_bar;
    logic [SPQ_W-1:0] sec_per_quarter;
    logic [QPB_W-1:0] quarter_per_bar;
    logic [SIG_W-1:0] sig_numerator;
    logic [SIG_W-1:0] sig_denominator;
  } row_t;

  typedef struct packed {
    logic              is_load;
    logic              slot_ok;
    logic [SLOT_W-1:0] slot;
    logic [1:0]        dom;
    logic [POS_W-1:0]  x;
    row_t              row;
  } cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0] segment_index;
    logic              found;
    logic [POS_W-1:0]  pos_sec;
    logic [POS_W-1:0]  pos_quarter;
    logic [POS_W-1:0]  pos_bar;
    logic [SPQ_W-1:0]  seg_sec_per_quarter;
    logic [QPB_W-1:0]  seg_quarter_per_bar;
    logic [SIG_W-1:0]  sig_numerator;
    logic [SIG_W-1:0]  sig_denominator;
  } res_t;

  typedef struct packed {
    logic             start;
    logic             is_div;
    logic [POS_W-1:0] a;
    logic [QPB_W-1:0] b;
  } arith_req_t;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] value;
  } arith_rsp_t;

endpackage

### sv/tmap_ram.sv
// generic simple dual port ram with registered read
module tmap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/tmap_fifo.sv
// small register fifo used between stages
module tmap_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### sv/tmap_front.sv
// front stage: takes input words and decodes them into commands
module tmap_front #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     op,
  input  logic [tmap_pkg::SLOT_W-1:0]    entry_index,
  input  logic [tmap_pkg::POS_W-1:0]     entry_start_sec,
  input  logic [tmap_pkg::POS_W-1:0]     entry_start_quarter,
  input  logic [tmap_pkg::POS_W-1:0]     entry_start_bar,
  input  logic [tmap_pkg::SPQ_W-1:0]     entry_sec_per_quarter,
  input  logic [tmap_pkg::QPB_W-1:0]     entry_quarter_per_bar,
  input  logic [tmap_pkg::SIG_W-1:0]     entry_sig_numerator,
  input  logic [tmap_pkg::SIG_W-1:0]     entry_sig_denominator,
  input  logic [tmap_pkg::POS_W-1:0]     query_time,
  output logic                           cmd_push,
  output tmap_pkg::cmd_t                 cmd,
  input  logic                           cmd_full
);
  import tmap_pkg::*;

  logic held;
  logic take;

  assign full     = held && cmd_full;
  assign take     = push && !full;
  assign cmd_push = held;

  always_ff @(posedge clk) begin
    if (take) begin
      cmd.is_load             <= (op == OP_LOAD);
      cmd.slot_ok             <= (32'(entry_index) < TABLE_DEPTH);
      cmd.slot                <= entry_index;
      cmd.dom                 <= op;
      cmd.x                   <= query_time;
      cmd.row.start_sec       <= entry_start_sec;
      cmd.row.start_quarter   <= entry_start_quarter;
      cmd.row.start_bar       <= entry_start_bar;
      cmd.row.sec_per_quarter <= entry_sec_per_quarter;
      cmd.row.quarter_per_bar <= entry_quarter_per_bar;
      cmd.row.sig_numerator   <= entry_sig_numerator;
      cmd.row.sig_denominator <= entry_sig_denominator;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (!cmd_full) begin
      held <= 1'b0;
    end
  end

endmodule

### sv/tmap_arith.sv
// shared serial divider and split multiplier, both saturating to the position range
module tmap_arith #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tmap_pkg::arith_req_t req,
  output tmap_pkg::arith_rsp_t rsp
);
  import tmap_pkg::*;

  localparam int NUM_W = POS_W + FRAC_BITS;
  localparam int CW    = $clog2(NUM_W + 1);

  localparam logic [1:0] A_IDLE = 2'd0;
  localparam logic [1:0] A_DIV  = 2'd1;
  localparam logic [1:0] A_M1   = 2'd2;
  localparam logic [1:0] A_M2   = 2'd3;

  logic [1:0]        st;
  logic [NUM_W-1:0]  num;
  logic [NUM_W-1:0]  quo;
  logic [QPB_W-1:0]  rem;
  logic [QPB_W-1:0]  dvs;
  logic [CW-1:0]     cnt;
  logic [HALF_W-1:0] mhi;
  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  acc;

  logic [QPB_W:0]    trial;
  logic              qbit;
  logic [NUM_W-1:0]  quo_next;
  logic [QPB_W-1:0]  rem_next;
  logic [ACC_W-1:0]  sum;

  always_comb begin
    trial    = {rem, num[NUM_W-1]};
    qbit     = (trial >= {1'b0, dvs});
    rem_next = qbit ? QPB_W'(trial - {1'b0, dvs}) : QPB_W'(trial);
    quo_next = {quo[NUM_W-2:0], qbit};
    sum      = acc + (ACC_W'(prod) << HALF_W);
  end

  always_ff @(posedge clk) begin
    case (st)
      A_IDLE: begin
        num  <= NUM_W'(req.a) << FRAC_BITS;
        quo  <= '0;
        rem  <= '0;
        dvs  <= req.b;
        cnt  <= CW'(NUM_W);
        mhi  <= req.a[POS_W-1:HALF_W];
        prod <= PROD_W'(req.a[HALF_W-1:0]) * PROD_W'(req.b);
      end
      A_DIV: begin
        num <= num << 1;
        quo <= quo_next;
        rem <= rem_next;
        cnt <= cnt - CW'(1);
      end
      A_M1: begin
        acc  <= ACC_W'(prod);
        prod <= PROD_W'(mhi) * PROD_W'(dvs);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= A_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (st == A_DIV && cnt == CW'(1)) begin
        rsp.value <= (|quo_next[NUM_W-1:POS_W]) ? POS_MAX : quo_next[POS_W-1:0];
      end else if (st == A_M2) begin
        rsp.value <= (|sum[ACC_W-1:NUM_W]) ? POS_MAX : sum[NUM_W-1:FRAC_BITS];
      end
      case (st)
        A_IDLE: begin
          if (req.start) begin
            st <= req.is_div ? A_DIV : A_M1;
          end
        end
        A_DIV: begin
          if (cnt == CW'(1)) begin
            st       <= A_IDLE;
            rsp.done <= 1'b1;
          end
        end
        A_M1: begin
          st <= A_M2;
        end
        A_M2: begin
          st       <= A_IDLE;
          rsp.done <= 1'b1;
        end
        default: begin
          st <= A_IDLE;
        end
      endcase
    end
  end

endmodule

### sv/tmap_back.sv
// back stage: table writes, segment search and domain conversion
module tmap_back #(
  parameter int TABLE_DEPTH = 64,
  parameter int FRAC_BITS   = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       entry_count_we,
  input  logic [tmap_pkg::CFG_W-1:0] entry_count,
  input  tmap_pkg::cmd_t             cmd,
  input  logic                       cmd_empty,
  output logic                       cmd_pop,
  output logic                       res_push,
  output tmap_pkg::res_t             res,
  input  logic                       res_full
);
  import tmap_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int ROW_W = $bits(row_t);

  localparam logic [SPQ_W-1:0] DEF_SPQ = SPQ_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic [QPB_W-1:0] DEF_QPB = QPB_W'(64'd4 << FRAC_BITS);
  localparam logic [SIG_W-1:0] DEF_SIG = SIG_W'(4);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PLAN = 4'd1;
  localparam logic [3:0] S_RDA  = 4'd2;
  localparam logic [3:0] S_RDB  = 4'd3;
  localparam logic [3:0] S_EVAL = 4'd4;
  localparam logic [3:0] S_C1   = 4'd5;
  localparam logic [3:0] S_W1   = 4'd6;
  localparam logic [3:0] S_C2   = 4'd7;
  localparam logic [3:0] S_W2   = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  localparam logic [1:0] PH_HINT = 2'd0;
  localparam logic [1:0] PH_NEXT = 2'd1;
  localparam logic [1:0] PH_LAST = 2'd2;
  localparam logic [1:0] PH_BIN  = 2'd3;

  logic [3:0]       state;
  logic [1:0]       phase;
  logic [CFG_W-1:0] count_reg;
  logic [1:0]       dom;
  logic [POS_W-1:0] x;
  logic [IDX_W-1:0] k;
  logic [CNT_W-1:0] lo;
  logic [CNT_W-1:0] hi1;
  logic [IDX_W-1:0] hint;
  logic             hint_none;
  row_t             row_a;
  logic [POS_W-1:0] r1;

  logic [ROW_W-1:0] rdata;
  row_t             row_b;
  logic [IDX_W-1:0] raddr;
  logic             ram_we;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] k_ext;
  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] c_next;
  logic [POS_W-1:0] key_a;
  logic [POS_W-1:0] key_b;
  logic [POS_W-1:0] delta;
  logic             last;
  logic             hit;
  logic             ge_b;
  arith_req_t       areq;
  arith_rsp_t       arsp;

  function automatic logic [POS_W-1:0] key_of(input row_t r, input logic [1:0] d);
    case (d)
      OP_SEC:     key_of = r.start_sec;
      OP_QUARTER: key_of = r.start_quarter;
      default:    key_of = r.start_bar;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                               input logic [POS_W-1:0] b);
    logic [POS_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[POS_W] ? POS_MAX : s[POS_W-1:0];
  endfunction

  assign n      = (32'(count_reg) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : CNT_W'(count_reg);
  assign k_ext  = CNT_W'(k);
  assign mid    = lo + ((hi1 - CNT_W'(1) - lo) >> 1);
  assign c_next = hint_none ? '0 : CNT_W'(hint) + CNT_W'(1);
  assign row_b  = row_t'(rdata);
  assign key_a  = key_of(row_a, dom);
  assign key_b  = key_of(row_b, dom);
  assign last   = (k_ext + CNT_W'(1) == n);
  assign ge_b   = (x >= key_b);
  assign hit    = (x >= key_a) && (last || !ge_b);
  assign delta  = x - key_a;
  assign raddr  = (state == S_RDB) ? k + IDX_W'(1) : k;
  assign ram_we = (state == S_IDLE) && !cmd_empty && cmd.is_load && cmd.slot_ok;
  assign cmd_pop  = (state == S_IDLE) && !cmd_empty;
  assign res_push = (state == S_OUT);

  tmap_ram #(
    .WIDTH (ROW_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(cmd.slot)),
    .wdata (ROW_W'(cmd.row)),
    .raddr (raddr),
    .rdata (rdata)
  );

  // first step: seconds divide by tempo, otherwise multiply
  always_comb begin
    areq.start  = (state == S_C1) || (state == S_C2);
    areq.is_div = 1'b1;
    areq.a      = delta;
    areq.b      = row_a.quarter_per_bar;
    if (state == S_C1) begin
      case (dom)
        OP_SEC: begin
          areq.b = QPB_W'(row_a.sec_per_quarter);
        end
        OP_QUARTER: begin
          areq.is_div = 1'b0;
          areq.b      = QPB_W'(row_a.sec_per_quarter);
        end
        default: begin
          areq.is_div = 1'b0;
        end
      endcase
    end else begin
      case (dom)
        OP_SEC: begin
          areq.a = r1;
        end
        OP_QUARTER: begin
        end
        default: begin
          areq.is_div = 1'b0;
          areq.a      = r1;
          areq.b      = QPB_W'(row_a.sec_per_quarter);
        end
      endcase
    end
  end

  tmap_arith #(
    .FRAC_BITS (FRAC_BITS)
  ) u_arith (
    .clk (clk),
    .rst (rst),
    .req (areq),
    .rsp (arsp)
  );

  always_ff @(posedge clk) begin
    if (state == S_IDLE && !cmd_empty) begin
      dom <= cmd.dom;
      x   <= cmd.x;
    end
    if (state == S_RDB) begin
      row_a <= row_b;
    end
    if (state == S_W1 && arsp.done) begin
      r1 <= arsp.value;
    end
    if (state == S_PLAN) begin
      case (phase)
        PH_HINT: k <= hint;
        PH_NEXT: k <= IDX_W'(c_next);
        PH_LAST: k <= IDX_W'(n - CNT_W'(1));
        default: k <= IDX_W'(mid);
      endcase
    end
    if (state == S_EVAL && !hit) begin
      if (phase == PH_LAST) begin
        lo  <= '0;
        hi1 <= n - CNT_W'(1);
      end else if (phase == PH_BIN) begin
        if (ge_b) begin
          lo <= k_ext + CNT_W'(1);
        end else begin
          hi1 <= k_ext;
        end
      end
    end
    // not found gives the queried position back and default segment data
    if (state == S_PLAN && ((phase == PH_LAST && n == '0) || (phase == PH_BIN && !(lo < hi1))))
    begin
      res.segment_index       <= '0;
      res.found               <= 1'b0;
      res.pos_sec             <= (dom == OP_SEC) ? x : '0;
      res.pos_quarter         <= (dom == OP_QUARTER) ? x : '0;
      res.pos_bar             <= (dom == OP_BAR) ? x : '0;
      res.seg_sec_per_quarter <= DEF_SPQ;
      res.seg_quarter_per_bar <= DEF_QPB;
      res.sig_numerator       <= DEF_SIG;
      res.sig_denominator     <= DEF_SIG;
    end
    if (state == S_W2 && arsp.done) begin
      res.segment_index       <= SLOT_W'(k);
      res.found               <= 1'b1;
      res.seg_sec_per_quarter <= row_a.sec_per_quarter;
      res.seg_quarter_per_bar <= row_a.quarter_per_bar;
      res.sig_numerator       <= row_a.sig_numerator;
      res.sig_denominator     <= row_a.sig_denominator;
      case (dom)
        OP_SEC: begin
          res.pos_sec     <= x;
          res.pos_quarter <= sat_add(row_a.start_quarter, r1);
          res.pos_bar     <= sat_add(row_a.start_bar, arsp.value);
        end
        OP_QUARTER: begin
          res.pos_quarter <= x;
          res.pos_sec     <= sat_add(row_a.start_sec, r1);
          res.pos_bar     <= sat_add(row_a.start_bar, arsp.value);
        end
        default: begin
          res.pos_bar     <= x;
          res.pos_quarter <= sat_add(row_a.start_quarter, r1);
          res.pos_sec     <= sat_add(row_a.start_sec, arsp.value);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_HINT;
      count_reg <= '0;
      hint      <= '0;
      hint_none <= 1'b1;
    end else begin
      if (entry_count_we) begin
        count_reg <= entry_count;
      end
      case (state)
        S_IDLE: begin
          if (!cmd_empty) begin
            phase <= PH_HINT;
            if (cmd.is_load) begin
              hint_none <= 1'b1;
            end else begin
              state <= S_PLAN;
            end
          end
        end
        S_PLAN: begin
          case (phase)
            PH_HINT: begin
              if (!hint_none && CNT_W'(hint) < n) begin
                state <= S_RDA;
              end else begin
                phase <= PH_NEXT;
              end
            end
            PH_NEXT: begin
              if (c_next < n) begin
                state <= S_RDA;
              end else begin
                phase <= PH_LAST;
              end
            end
            PH_LAST: begin
              if (n != '0) begin
                state <= S_RDA;
              end else begin
                hint_none <= 1'b1;
                state     <= S_OUT;
              end
            end
            default: begin
              if (lo < hi1) begin
                state <= S_RDA;
              end else begin
                hint_none <= 1'b1;
                state     <= S_OUT;
              end
            end
          endcase
        end
        S_RDA: begin
          state <= S_RDB;
        end
        S_RDB: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (hit) begin
            // a hit on the hint itself leaves it alone
            if (phase != PH_HINT) begin
              hint      <= k;
              hint_none <= 1'b0;
            end
            state <= S_C1;
          end else begin
            state <= S_PLAN;
            case (phase)
              PH_HINT: phase <= PH_NEXT;
              PH_NEXT: phase <= PH_LAST;
              default: phase <= PH_BIN;
            endcase
          end
        end
        S_C1: begin
          state <= S_W1;
        end
        S_W1: begin
          if (arsp.done) begin
            state <= S_C2;
          end
        end
        S_C2: begin
          state <= S_W2;
        end
        S_W2: begin
          if (arsp.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### sv/tempo_map_segment_lookup_convert.sv
// tempo map lookup: a load word passes through front, queue and one table write.
// a query probes the table, at most 3 + log2(TABLE_DEPTH) probes, and if a segment is
// found runs two steps on one shared unit, each a division (bit-serial divider)
// or a multiply (split into two partial products).
// the back end works on one word at a time; the front and a 2-word queue keep taking input.
// reset clears entry_count, the hint and both queues; table contents stay undefined until loaded.
module tempo_map_segment_lookup_convert #(
  parameter int TABLE_DEPTH = 64,
  parameter int FRAC_BITS   = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  op,
  input  logic [tmap_pkg::SLOT_W-1:0] entry_index,
  input  logic [tmap_pkg::POS_W-1:0]  entry_start_sec,
  input  logic [tmap_pkg::POS_W-1:0]  entry_start_quarter,
  input  logic [tmap_pkg::POS_W-1:0]  entry_start_bar,
  input  logic [tmap_pkg::SPQ_W-1:0]  entry_sec_per_quarter,
  input  logic [tmap_pkg::QPB_W-1:0]  entry_quarter_per_bar,
  input  logic [tmap_pkg::SIG_W-1:0]  entry_sig_numerator,
  input  logic [tmap_pkg::SIG_W-1:0]  entry_sig_denominator,
  input  logic [tmap_pkg::POS_W-1:0]  query_time,
  input  logic                        entry_count_we,
  input  logic [tmap_pkg::CFG_W-1:0]  entry_count,
  output logic                        empty,
  input  logic                        pop,
  output logic [tmap_pkg::SLOT_W-1:0] segment_index,
  output logic                        found,
  output logic [tmap_pkg::POS_W-1:0]  pos_sec,
  output logic [tmap_pkg::POS_W-1:0]  pos_quarter,
  output logic [tmap_pkg::POS_W-1:0]  pos_bar,
  output logic [tmap_pkg::SPQ_W-1:0]  seg_sec_per_quarter,
  output logic [tmap_pkg::QPB_W-1:0]  seg_quarter_per_bar,
  output logic [tmap_pkg::SIG_W-1:0]  sig_numerator,
  output logic [tmap_pkg::SIG_W-1:0]  sig_denominator
);
  import tmap_pkg::*;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

  cmd_t             front_cmd;
  logic             front_push;
  logic             cmd_full;
  logic [CMD_W-1:0] cmd_bits;
  logic             cmd_empty;
  logic             cmd_pop;
  res_t             back_res;
  logic             res_push;
  logic             res_full;
  logic [RES_W-1:0] res_bits;
  res_t             head;

  tmap_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk                   (clk),
    .rst                   (rst),
    .push                  (push),
    .full                  (full),
    .op                    (op),
    .entry_index           (entry_index),
    .entry_start_sec       (entry_start_sec),
    .entry_start_quarter   (entry_start_quarter),
    .entry_start_bar       (entry_start_bar),
    .entry_sec_per_quarter (entry_sec_per_quarter),
    .entry_quarter_per_bar (entry_quarter_per_bar),
    .entry_sig_numerator   (entry_sig_numerator),
    .entry_sig_denominator (entry_sig_denominator),
    .query_time            (query_time),
    .cmd_push              (front_push),
    .cmd                   (front_cmd),
    .cmd_full              (cmd_full)
  );

  tmap_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (front_push),
    .wdata (CMD_W'(front_cmd)),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_bits),
    .empty (cmd_empty)
  );

  tmap_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .entry_count_we (entry_count_we),
    .entry_count    (entry_count),
    .cmd            (cmd_t'(cmd_bits)),
    .cmd_empty      (cmd_empty),
    .cmd_pop        (cmd_pop),
    .res_push       (res_push),
    .res            (back_res),
    .res_full       (res_full)
  );

  tmap_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (RES_W'(back_res)),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_bits),
    .empty (empty)
  );

  assign head                = res_t'(res_bits);
  assign segment_index       = head.segment_index;
  assign found               = head.found;
  assign pos_sec             = head.pos_sec;
  assign pos_quarter         = head.pos_quarter;
  assign pos_bar             = head.pos_bar;
  assign seg_sec_per_quarter = head.seg_sec_per_quarter;
  assign seg_quarter_per_bar = head.seg_quarter_per_bar;
  assign sig_numerator       = head.sig_numerator;
  assign sig_denominator     = head.sig_denominator;

endmodule
